[src/scesp_pkg.sv]
package scesp_pkg;

    // Sample memory size in bytes (default for the top-level parameter)
    localparam int SAMPLE_BYTES_DEF = 8192;

    localparam int CMD_W      = 3;
    localparam int DATA_W     = 8;
    localparam int MEM_ADDR_W = 13;

    typedef enum logic [CMD_W-1:0] {
        CMD_WR_HIGH  = 3'd0,
        CMD_WR_LOW   = 3'd1,
        CMD_SEL      = 3'd2,
        CMD_START    = 3'd3,
        CMD_READ     = 3'd4,
        CMD_TICK     = 3'd5,
        CMD_LOAD     = 3'd6,
        CMD_NOP      = 3'd7
    } scesp_cmd_t;

endpackage

[src/scesp_req_if.sv]
interface scesp_req_if
    import scesp_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CMD_W-1:0]      command;
    logic [DATA_W-1:0]     data;
    logic [MEM_ADDR_W-1:0] mem_address;

    modport source (output valid, output command, output data, output mem_address,
                    input ready);
    modport sink   (input valid, input command, input data, input mem_address,
                    output ready);
endinterface

[src/scesp_rsp_if.sv]
interface scesp_rsp_if
    import scesp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic              sample_bit;
    logic              sample_bit_valid;
    logic              freeze_level;

    modport source (output valid, output read_data, output sample_bit,
                    output sample_bit_valid, output freeze_level, input ready);
    modport sink   (input valid, input read_data, input sample_bit,
                    input sample_bit_valid, input freeze_level, output ready);
endinterface

[src/scesp_sample_mem.sv]
module scesp_sample_mem
    import scesp_pkg::*;
#(
    parameter int DEPTH = SAMPLE_BYTES_DEF,
    localparam int AW   = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/sound_command_encoder_sample_player.sv]
// The response is registered, valid in the cycle after its request is accepted.
// Throughput: one request per cycle while rsp.ready drains each response; the
// response register frees up in the same cycle its transfer completes, and the
// sample memory's single read port serves one tick per cycle.
// Reset (rst_n, async, active low): command word, nibble latches, sample select,
// bit address and freeze level go to zero; sample memory is not cleared.
module sound_command_encoder_sample_player
    import scesp_pkg::*;
#(
    parameter int SAMPLE_BYTES = SAMPLE_BYTES_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    scesp_req_if.sink    req,
    scesp_rsp_if.source  rsp
);

    localparam int AW = $clog2(SAMPLE_BYTES);

    // Low nibble: lowest set bit i of cmd[15:6] gives (16 - i) & 15, none gives 0.
    function automatic logic [3:0] enc_high_field(input logic [15:0] w);
        logic [3:0] res;
        res = 4'd0;
        for (int i = 15; i >= 6; i--)
        begin
            if (w[i])
            begin
                res = 4'(16 - i);
            end
        end
        return res;
    endfunction

    // High nibble: highest set bit i of cmd[5:0] gives 5 - i.
    function automatic logic [3:0] enc_low_field(input logic [5:0] w);
        logic [3:0] res;
        res = 4'd0;
        for (int i = 0; i < 6; i++)
        begin
            if (w[i])
            begin
                res = 4'(5 - i);
            end
        end
        return res;
    endfunction

    // Architectural state
    logic [15:0] cmd_word_reg,    cmd_word_next;
    logic [3:0]  low_nib_reg,     low_nib_next;
    logic [3:0]  high_nib_reg,    high_nib_next;
    logic [7:0]  sample_sel_reg,  sample_sel_next;
    logic [15:0] bit_addr_reg,    bit_addr_next;
    logic        freeze_reg,      freeze_next;

    // Response register
    logic        res_valid_reg;
    logic [7:0]  res_read_data_reg, res_read_data_next;
    logic        res_tick_reg,      res_tick_next;
    logic [2:0]  res_bit_sel_reg;

    logic        accept;
    logic        tick_rise;
    logic        mem_wr;
    logic [7:0]  mem_q;
    scesp_cmd_t  cmd;

    assign cmd       = scesp_cmd_t'(req.command);
    // Response slot is free when empty or being drained this cycle
    assign req.ready = !res_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign tick_rise = (cmd == CMD_TICK) && req.data[0];
    assign mem_wr    = accept && (cmd == CMD_LOAD);

    always_comb
    begin
        cmd_word_next      = cmd_word_reg;
        low_nib_next       = low_nib_reg;
        high_nib_next      = high_nib_reg;
        sample_sel_next    = sample_sel_reg;
        bit_addr_next      = bit_addr_reg;
        freeze_next        = freeze_reg;
        res_read_data_next = 8'd0;
        res_tick_next      = 1'b0;

        case (cmd)
            CMD_WR_HIGH, CMD_WR_LOW:
            begin
                if (cmd == CMD_WR_HIGH)
                begin
                    cmd_word_next = {req.data, cmd_word_reg[7:0]};
                end
                else
                begin
                    cmd_word_next = {cmd_word_reg[15:8], req.data};
                end
                // Edge trigger on the low six bits
                if (cmd_word_next[5:0] != 6'd0 && cmd_word_next[5:0] != cmd_word_reg[5:0])
                begin
                    high_nib_next = enc_low_field(cmd_word_next[5:0]);
                end
                low_nib_next = enc_high_field(cmd_word_next);
            end
            CMD_SEL:
            begin
                sample_sel_next = req.data;
            end
            CMD_START:
            begin
                if (req.data[7])
                begin
                    high_nib_next = 4'd0;
                    bit_addr_next = {sample_sel_reg, 8'd0};
                end
                freeze_next = req.data[7];
            end
            CMD_READ:
            begin
                res_read_data_next = {high_nib_reg, low_nib_reg};
            end
            CMD_TICK:
            begin
                if (req.data[0])
                begin
                    res_tick_next = 1'b1;
                    bit_addr_next = bit_addr_reg + 16'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_word_reg   <= '0;
            low_nib_reg    <= '0;
            high_nib_reg   <= '0;
            sample_sel_reg <= '0;
            bit_addr_reg   <= '0;
            freeze_reg     <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                cmd_word_reg   <= cmd_word_next;
                low_nib_reg    <= low_nib_next;
                high_nib_reg   <= high_nib_next;
                sample_sel_reg <= sample_sel_next;
                bit_addr_reg   <= bit_addr_next;
                freeze_reg     <= freeze_next;
                res_valid_reg  <= 1'b1;
            end
            else if (rsp.ready)
            begin
                res_valid_reg  <= 1'b0;
            end
        end
    end

    // Response payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_read_data_reg <= res_read_data_next;
            res_tick_reg      <= res_tick_next;
            res_bit_sel_reg   <= bit_addr_reg[2:0];
        end
    end

    // Sample memory: tick reads the byte under the current bit address, read data
    // lands alongside the response register and holds while it stalls.
    scesp_sample_mem #(
        .DEPTH (SAMPLE_BYTES)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr),
        .wr_addr (req.mem_address[AW-1:0]),
        .wr_data (req.data),
        .rd_en   (accept && tick_rise),
        .rd_addr (bit_addr_reg[3 +: AW]),
        .rd_data (mem_q)
    );

    assign rsp.valid            = res_valid_reg;
    assign rsp.read_data        = res_read_data_reg;
    // MSB first: bit 7 - offset
    assign rsp.sample_bit       = res_tick_reg && mem_q[3'd7 - res_bit_sel_reg];
    assign rsp.sample_bit_valid = res_tick_reg;
    // freeze_reg cannot move while this response is pending
    assign rsp.freeze_level     = freeze_reg;

    // Rising tick advances the bit address by one
    a_tick_adv: assert property (@(posedge clk) disable iff (!rst_n)
        accept && tick_rise |=> bit_addr_reg == $past(bit_addr_reg) + 16'd1)
        else $error("bit address did not advance on tick");

    // Sample start with bit7 clears the high nibble and raises freeze
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd == CMD_START && req.data[7] |=> high_nib_reg == 4'd0 && freeze_reg)
        else $error("sample start did not take effect");

    // Readback only on a read
    a_rd_only: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd != CMD_READ |=> res_read_data_reg == 8'd0)
        else $error("read data nonzero on non-read");

    // No sample bit without a tick
    a_bit_qual: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.sample_bit_valid |-> !rsp.sample_bit)
        else $error("sample bit without tick");

    // Every accepted request yields a pending response
    a_resp: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> res_valid_reg)
        else $error("response lost");

endmodule
